@@ design/fbf_pkg.sv @@
`default_nettype none
package fbf_pkg;

  localparam int unsigned HEAP_BYTES      = 1048576;
  localparam int unsigned HDR_BYTES       = 16;
  localparam int unsigned MIN_BYTES       = 16;
  localparam int unsigned MAX_BLOCKS_DEF  = 64;
  localparam int unsigned OFF_W           = 20;
  localparam int unsigned SZ_W            = 21;
  localparam int unsigned CNT_PORT_W      = 7;
  localparam int unsigned FRAC_W          = 16;

  localparam logic [SZ_W-1:0] HEAP_DATA = SZ_W'(HEAP_BYTES - HDR_BYTES);
  localparam logic [SZ_W-1:0] HDR_SZ    = SZ_W'(HDR_BYTES);
  localparam logic [SZ_W-1:0] MIN_SZ    = SZ_W'(MIN_BYTES);
  localparam logic [SZ_W-1:0] SPLIT_MIN = SZ_W'(MIN_BYTES + HDR_BYTES);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROT,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [SZ_W-1:0]  size;
    logic             used;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   ent;
  } cmd_t;

  typedef struct packed {
    logic             func;
    logic [SZ_W-1:0]  req_size;
    logic [OFF_W-1:0] free_addr;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [OFF_W-1:0]      data_addr;
    logic [OFF_W-1:0]      bytes_allocated;
    logic [OFF_W-1:0]      bytes_free;
    logic [CNT_PORT_W-1:0] used_count;
    logic [CNT_PORT_W-1:0] free_count;
    logic [OFF_W-1:0]      largest_free;
    logic [FRAC_W-1:0]     fragmentation;
  } out_word_t;

endpackage
`default_nettype wire

@@ design/fbf_cell.sv @@
`default_nettype none
module fbf_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fbf_pkg::cmd_t     cmd_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire fbf_pkg::entry_t   left_i,
  input  wire fbf_pkg::entry_t   right_i,
  output fbf_pkg::entry_t        ent_o
);
  import fbf_pkg::*;

  entry_t ent_q, ent_d;
  logic   here, above;

  assign here  = (idx_i == IDX_W'(IDX));
  assign above = (IDX_W'(IDX) > idx_i);

  always_comb begin
    ent_d = ent_q;
    unique case (cmd_i.op)
      OP_ROT:    ent_d = right_i;
      OP_WRITE:  if (here) ent_d = cmd_i.ent;
      OP_INSERT: begin
        if (here) begin
          ent_d = cmd_i.ent;
        end else if (above) begin
          ent_d = left_i;
        end
      end
      OP_REMOVE: if (here || above) ent_d = right_i;
      default:   ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      if (IDX == 0) begin
        ent_q <= '{off: '0, size: HEAP_DATA, used: 1'b0};
      end else begin
        ent_q <= '0;
      end
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule
`default_nettype wire

@@ design/fbf_frac.sv @@
`default_nettype none
module fbf_frac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [fbf_pkg::SZ_W-1:0]      free_i,
  input  wire logic [fbf_pkg::SZ_W-1:0]      large_i,
  output logic                               done_o,
  output logic [fbf_pkg::FRAC_W-1:0]         frac_o
);
  import fbf_pkg::*;

  localparam int unsigned CW = $clog2(FRAC_W + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [SZ_W-1:0]   div_q, rem_q;
  logic [FRAC_W-1:0] quo_q;
  logic [SZ_W:0]     rem2;
  logic              ge;

  assign rem2 = {rem_q, 1'b0};
  assign ge   = (rem2 >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (free_i == '0 || large_i > free_i || large_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(FRAC_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= free_i;
      rem_q <= free_i - large_i;
      if (free_i == '0 || large_i > free_i) begin
        quo_q <= '0;
      end else if (large_i == '0) begin
        quo_q <= '1;
      end else begin
        quo_q <= '0;
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= SZ_W'(rem2 - {1'b0, div_q});
      end else begin
        rem_q <= SZ_W'(rem2);
      end
      quo_q <= {quo_q[FRAC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign frac_o = quo_q;

endmodule
`default_nettype wire

@@ design/first_best_fit_heap_allocator.sv @@
`default_nettype none
// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_ready_o    fbf_pkg::in_word_t
// out       output     out_valid_o / out_ready_i  fbf_pkg::out_word_t
// cfg       input      cfg_valid_i / cfg_ready_o  fit policy bit
// A request rotates the cell ring once to search, passes the table update states S_M1 to
// S_M4, rotates it again to find the largest free block and runs a 16-step serial fraction
// divide. Failed requests skip S_M2 to S_LARGE; a zero-size one goes straight to the divide.
// Reset restores the single free block at once; no clearing pass is needed.
// A new word is taken only when the previous request has left the pipeline; a result that is
// not taken stalls the block before its output register is reloaded.
module first_best_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS = fbf_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire fbf_pkg::in_word_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output fbf_pkg::out_word_t       out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i
);
  import fbf_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_M1     = 4'd2;
  localparam logic [3:0] S_M2     = 4'd3;
  localparam logic [3:0] S_M3     = 4'd4;
  localparam logic [3:0] S_M4     = 4'd5;
  localparam logic [3:0] S_LARGE  = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DWAIT  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0]       state_q, state_d;
  logic             fit_q;
  logic [CNT_W-1:0] total_q, used_q, fcnt_q;
  logic [SZ_W-1:0]  alloc_q, freeb_q, large_q;
  logic             func_q;
  logic [SZ_W-1:0]  sz_q;
  logic [OFF_W-1:0] addr_q;
  logic [IDX_W-1:0] step_q, pick_q;
  logic             found_q, idx_used_q, split_q;
  logic [SZ_W-1:0]  best_q, merged_q, run_max_q;
  logic [OFF_W-1:0] pick_off_q, pred_off_q, prev_off_q;
  logic             pred_free_q, succ_free_q, prev_used_q;
  logic [SZ_W-1:0]  pred_size_q, succ_size_q, prev_size_q;
  logic [1:0]       st_q;
  logic [OFF_W-1:0] data_q;
  logic             out_valid_q;
  out_word_t        out_q;

  cmd_t             cmd;
  logic [IDX_W-1:0] cmd_idx;
  entry_t           ents [MAX_BLOCKS];
  entry_t           head;
  logic             live, last_step, fit, match;
  logic             frac_start, frac_done;
  logic [FRAC_W-1:0] frac;
  logic [SZ_W-1:0]  s1;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    fbf_cell #(.IDX(k), .IDX_W(IDX_W)) u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i  (cmd),
      .idx_i  (cmd_idx),
      .left_i (ents[(k + MAX_BLOCKS - 1) % MAX_BLOCKS]),
      .right_i(ents[(k + 1) % MAX_BLOCKS]),
      .ent_o  (ents[k])
    );
  end

  fbf_frac u_frac (
    .clk_i,
    .rst_ni,
    .start_i(frac_start),
    .free_i (freeb_q),
    .large_i(large_q),
    .done_o (frac_done),
    .frac_o (frac)
  );

  assign head       = ents[0];
  assign live       = (CNT_W'(step_q) < total_q);
  assign last_step  = (step_q == IDX_W'(MAX_BLOCKS - 1));
  assign fit        = live && !head.used && (head.size >= sz_q);
  assign match      = live && !found_q && ((SZ_W'(head.off) + HDR_SZ) == SZ_W'(addr_q));
  assign frac_start = (state_q == S_DSTART);
  assign s1         = succ_free_q ? SZ_W'(best_q + succ_size_q + HDR_SZ) : best_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cmd     = '{op: OP_NONE, ent: '0};
    cmd_idx = pick_q;
    unique case (state_q)
      S_SCAN, S_LARGE: cmd.op = OP_ROT;
      S_M1: begin
        if (func_q == FUNC_ALLOC && found_q) begin
          cmd.op  = OP_WRITE;
          cmd.ent = '{off: pick_off_q,
                      size: (((best_q - sz_q) >= SPLIT_MIN) && (total_q < CNT_W'(MAX_BLOCKS)))
                            ? sz_q : best_q,
                      used: 1'b1};
        end else if (func_q == FUNC_FREE && found_q && idx_used_q) begin
          cmd.op  = OP_WRITE;
          cmd.ent = '{off: pick_off_q, size: s1, used: 1'b0};
        end
      end
      S_M2: begin
        cmd_idx = pick_q + 1'b1;
        if (func_q == FUNC_ALLOC && split_q) begin
          cmd.op  = OP_INSERT;
          cmd.ent = '{off: pick_off_q + OFF_W'(HDR_BYTES) + OFF_W'(sz_q),
                      size: best_q - sz_q - HDR_SZ, used: 1'b0};
        end else if (func_q == FUNC_FREE && succ_free_q) begin
          cmd.op = OP_REMOVE;
        end
      end
      S_M3: begin
        cmd_idx = pick_q - 1'b1;
        if (func_q == FUNC_FREE && pred_free_q) begin
          cmd.op  = OP_WRITE;
          cmd.ent = '{off: pred_off_q, size: SZ_W'(pred_size_q + merged_q + HDR_SZ),
                      used: 1'b0};
        end
      end
      S_M4: if (func_q == FUNC_FREE && pred_free_q) cmd.op = OP_REMOVE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.func == FUNC_ALLOC && in_data_i.req_size == '0) begin
            state_d = S_DSTART;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: if (last_step) state_d = S_M1;
      S_M1: begin
        if (found_q && (func_q == FUNC_ALLOC || idx_used_q)) begin
          state_d = S_M2;
        end else begin
          state_d = S_DSTART;
        end
      end
      S_M2:     state_d = S_M3;
      S_M3:     state_d = S_M4;
      S_M4:     state_d = S_LARGE;
      S_LARGE:  if (last_step) state_d = S_DSTART;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT:  if (frac_done) state_d = S_OUT;
      S_OUT:    if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fit_q       <= 1'b0;
      total_q     <= CNT_W'(1);
      used_q      <= '0;
      fcnt_q      <= CNT_W'(1);
      alloc_q     <= '0;
      freeb_q     <= HEAP_DATA;
      large_q     <= HEAP_DATA;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) fit_q <= cfg_data_i;
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          step_q  <= '0;
          found_q <= 1'b0;
        end
        S_SCAN: begin
          step_q <= last_step ? '0 : step_q + 1'b1;
          if (func_q == FUNC_ALLOC) begin
            if (fit && (!found_q || (fit_q && head.size < best_q))) found_q <= 1'b1;
          end else if (match) begin
            found_q <= 1'b1;
          end
        end
        S_M1: begin
          if (func_q == FUNC_ALLOC && found_q) begin
            if (((best_q - sz_q) >= SPLIT_MIN) && (total_q < CNT_W'(MAX_BLOCKS))) begin
              alloc_q <= alloc_q + sz_q;
              freeb_q <= freeb_q - sz_q;
            end else begin
              alloc_q <= alloc_q + best_q;
              freeb_q <= freeb_q - best_q;
              fcnt_q  <= fcnt_q - 1'b1;
            end
            used_q <= used_q + 1'b1;
          end else if (func_q == FUNC_FREE && found_q && idx_used_q) begin
            alloc_q <= alloc_q - best_q;
            freeb_q <= freeb_q + best_q;
            used_q  <= used_q - 1'b1;
            fcnt_q  <= fcnt_q + 1'b1 - CNT_W'(succ_free_q) - CNT_W'(pred_free_q);
          end
        end
        S_M2: begin
          if (func_q == FUNC_ALLOC && split_q) begin
            total_q <= total_q + 1'b1;
          end else if (func_q == FUNC_FREE && succ_free_q) begin
            total_q <= total_q - 1'b1;
          end
        end
        S_M4: begin
          step_q <= '0;
          if (func_q == FUNC_FREE && pred_free_q) total_q <= total_q - 1'b1;
        end
        S_LARGE: begin
          step_q <= last_step ? '0 : step_q + 1'b1;
          if (last_step) begin
            large_q <= (live && !head.used && head.size > run_max_q) ? head.size : run_max_q;
          end
        end
        S_OUT: if (!out_valid_q || out_ready_i) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        func_q      <= in_data_i.func;
        sz_q        <= (in_data_i.req_size < MIN_SZ && in_data_i.req_size != '0)
                       ? MIN_SZ : in_data_i.req_size;
        addr_q      <= in_data_i.free_addr;
        succ_free_q <= 1'b0;
        pred_free_q <= 1'b0;
        st_q        <= ST_ZERO;
        data_q      <= '0;
      end
      S_SCAN: begin
        prev_used_q <= head.used;
        prev_size_q <= head.size;
        prev_off_q  <= head.off;
        if (func_q == FUNC_ALLOC) begin
          if (fit && (!found_q || (fit_q && head.size < best_q))) begin
            pick_q     <= step_q;
            best_q     <= head.size;
            pick_off_q <= head.off;
          end
        end else begin
          if (match) begin
            pick_q      <= step_q;
            best_q      <= head.size;
            pick_off_q  <= head.off;
            idx_used_q  <= head.used;
            pred_free_q <= (step_q != '0) && !prev_used_q;
            pred_size_q <= prev_size_q;
            pred_off_q  <= prev_off_q;
          end
          if (found_q && live && step_q == pick_q + 1'b1) begin
            succ_free_q <= !head.used;
            succ_size_q <= head.size;
          end
        end
      end
      S_M1: begin
        split_q  <= ((best_q - sz_q) >= SPLIT_MIN) && (total_q < CNT_W'(MAX_BLOCKS));
        merged_q <= s1;
        if (!found_q) begin
          st_q <= (func_q == FUNC_ALLOC) ? ST_NOFIT : ST_BADFREE;
        end else if (func_q == FUNC_FREE && !idx_used_q) begin
          st_q <= ST_BADFREE;
        end else begin
          st_q   <= ST_OK;
          data_q <= (func_q == FUNC_ALLOC) ? pick_off_q + OFF_W'(HDR_BYTES) : '0;
        end
      end
      S_M4: run_max_q <= '0;
      S_LARGE: begin
        if (live && !head.used && head.size > run_max_q) run_max_q <= head.size;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.status          <= st_q;
          out_q.data_addr       <= data_q;
          out_q.bytes_allocated <= OFF_W'(alloc_q);
          out_q.bytes_free      <= OFF_W'(freeb_q);
          out_q.used_count      <= CNT_PORT_W'(used_q);
          out_q.free_count      <= CNT_PORT_W'(fcnt_q);
          out_q.largest_free    <= OFF_W'(large_q);
          out_q.fragmentation   <= frac;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) && (total_q <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (CNT_W'(used_q + fcnt_q) == total_q))
    else $error("used and free counts disagree with the table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_done |-> (state_q == S_DWAIT))
    else $error("fraction unit finished outside its wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_valid_q) |=> out_valid_q && (state_q == S_IDLE))
    else $error("result word not loaded");

endmodule
`default_nettype wire
